// ===== rtl/cossim_pkg.sv =====
// Shared constants and controller/datapath interface types for the cosine similarity block.
`timescale 1ns / 1ps
`default_nettype none
package cossim_pkg;

  localparam int MAX_LEN_DEF = 512;
  localparam int ELEM_W      = 16;
  localparam int ACC_W       = 48;
  localparam int ROOT_W      = ACC_W / 2;
  localparam int SQRT_STEPS  = ROOT_W;
  localparam int DIV_STEPS   = 16;
  localparam int STEP_W      = $clog2(SQRT_STEPS);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;       // word accepted: register the products
    logic load;       // capture sums into the root and divide units, clear sums
    logic sqrt_step;  // one root digit for both norms
    logic mul;        // multiply the roots, seed the divider
    logic div_step;   // one quotient bit
    logic out_load;   // write the result register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sqrt_last;
    logic div_last;
  } sts_t;

endpackage
`default_nettype wire

// ===== rtl/cossim_dp.sv =====
// Datapath: accumulators, two digit-serial square root lanes, root product and divider.
`timescale 1ns / 1ps
`default_nettype none
module cossim_dp #(
  parameter int MAX_LEN = cossim_pkg::MAX_LEN_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire cossim_pkg::cmd_t                       cmd,
  output cossim_pkg::sts_t                            sts,
  input  wire logic signed [cossim_pkg::ELEM_W-1:0]   elem_a,
  input  wire logic signed [cossim_pkg::ELEM_W-1:0]   elem_b,
  output logic signed [cossim_pkg::ELEM_W-1:0]        similarity,
  output logic                                        zero_norm,
  output logic                                        too_long
);
  import cossim_pkg::*;

  localparam int CNT_W  = $clog2(MAX_LEN + 2);
  localparam int PROD_W = 2 * ELEM_W;
  localparam int REM_W  = ROOT_W + 2;

  // Product stage.
  logic                     pv;
  logic signed [PROD_W-1:0] p_ab, p_aa, p_bb;

  // Accumulators.
  logic [ACC_W-1:0] dot_sum, norm_a_sum, norm_b_sum;
  logic [CNT_W-1:0] pair_count;

  // Captured at load.
  logic [ACC_W-1:0] mag;
  logic             neg;
  logic             long_flag;

  // Square root lanes: 0 for norm a, 1 for norm b.
  logic [ACC_W-1:0]  sq_src  [2];
  logic [REM_W-1:0]  sq_rem  [2];
  logic [ROOT_W-1:0] sq_root [2];
  logic [REM_W:0]    rem_sh  [2];
  logic [REM_W:0]    trial   [2];
  logic              sq_ge   [2];

  // Divider.
  logic [STEP_W-1:0]    step;
  logic [ACC_W-1:0]     prod;
  logic [ACC_W:0]       div_rem;
  logic [ACC_W:0]       div_sh;
  logic                 div_ge;
  logic [DIV_STEPS-1:0] quo;
  logic [ELEM_W-1:0]    sim_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= 1'b0;
    end else begin
      pv <= cmd.take;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      p_ab <= elem_a * elem_b;
      p_aa <= elem_a * elem_a;
      p_bb <= elem_b * elem_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dot_sum    <= '0;
      norm_a_sum <= '0;
      norm_b_sum <= '0;
      pair_count <= '0;
    end else if (cmd.load) begin
      dot_sum    <= '0;
      norm_a_sum <= '0;
      norm_b_sum <= '0;
      pair_count <= '0;
    end else begin
      if (pv) begin
        dot_sum    <= dot_sum    + ACC_W'(p_ab);
        norm_a_sum <= norm_a_sum + ACC_W'(p_aa);
        norm_b_sum <= norm_b_sum + ACC_W'(p_bb);
      end
      // saturate one past the limit, enough to tell an over-long vector
      if (cmd.take && pair_count != CNT_W'(MAX_LEN + 1)) begin
        pair_count <= pair_count + 1'b1;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      rem_sh[i] = {sq_rem[i][REM_W-2:0], sq_src[i][ACC_W-1 -: 2]};
      trial[i]  = {1'b0, sq_root[i], 2'b01};
      sq_ge[i]  = rem_sh[i] >= trial[i];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sq_src[0]  <= norm_a_sum;
      sq_src[1]  <= norm_b_sum;
      sq_rem[0]  <= '0;
      sq_rem[1]  <= '0;
      sq_root[0] <= '0;
      sq_root[1] <= '0;
      neg        <= dot_sum[ACC_W-1];
      mag        <= dot_sum[ACC_W-1] ? (~dot_sum + 1'b1) : dot_sum;
      long_flag  <= pair_count > CNT_W'(MAX_LEN);
    end else if (cmd.sqrt_step) begin
      for (int i = 0; i < 2; i++) begin
        sq_src[i]  <= {sq_src[i][ACC_W-3:0], 2'b00};
        sq_rem[i]  <= sq_ge[i] ? REM_W'(rem_sh[i] - trial[i]) : REM_W'(rem_sh[i]);
        sq_root[i] <= {sq_root[i][ROOT_W-2:0], sq_ge[i]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else if (cmd.load || cmd.mul) begin
      step <= '0;
    end else if (cmd.sqrt_step || cmd.div_step) begin
      step <= step + 1'b1;
    end
  end

  assign sts.sqrt_last = step == STEP_W'(SQRT_STEPS - 1);
  assign sts.div_last  = step == STEP_W'(DIV_STEPS - 1);

  // First step compares without a shift: a set top bit means the ratio reached one.
  always_comb begin
    div_sh = (step == '0) ? div_rem : {div_rem[ACC_W-1:0], 1'b0};
    div_ge = div_sh >= {1'b0, prod};
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod    <= sq_root[0] * sq_root[1];
      div_rem <= {1'b0, mag};
      quo     <= '0;
    end else if (cmd.div_step) begin
      div_rem <= div_ge ? (div_sh - {1'b0, prod}) : div_sh;
      quo     <= {quo[DIV_STEPS-2:0], div_ge};
    end
  end

  always_comb begin
    if (neg) begin
      sim_next = quo[DIV_STEPS-1] ? {1'b1, {(ELEM_W-1){1'b0}}} : ELEM_W'(~quo + 1'b1);
    end else begin
      sim_next = quo[DIV_STEPS-1] ? {1'b0, {(ELEM_W-1){1'b1}}} : ELEM_W'(quo);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (sq_root[0] == '0 || sq_root[1] == '0) begin
        similarity <= '0;
        zero_norm  <= 1'b1;
      end else begin
        similarity <= signed'(sim_next);
        zero_norm  <= 1'b0;
      end
      too_long <= long_flag;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/cossim_ctrl.sv =====
// Controller: sequences accumulate, root, multiply, divide and result hand-off.
`timescale 1ns / 1ps
`default_nettype none
module cossim_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic             last_pair,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output cossim_pkg::cmd_t      cmd,
  input  wire cossim_pkg::sts_t sts
);
  import cossim_pkg::*;

  typedef enum logic [6:0] {
    S_ACC   = 7'b0000001,
    S_FLUSH = 7'b0000010,
    S_LOAD  = 7'b0000100,
    S_SQRT  = 7'b0001000,
    S_MUL   = 7'b0010000,
    S_DIV   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic   take;
  logic   slot_free;

  assign in_stall  = state != S_ACC;
  assign take      = in_valid && !in_stall;
  assign slot_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    unique case (state)
      S_ACC:   if (take && last_pair) state_next = S_FLUSH;
      S_FLUSH: state_next = S_LOAD;
      S_LOAD:  state_next = S_SQRT;
      S_SQRT:  if (sts.sqrt_last) state_next = S_MUL;
      S_MUL:   state_next = S_DIV;
      S_DIV:   if (sts.div_last) state_next = S_OUT;
      S_OUT:   if (slot_free) state_next = S_ACC;
      default: state_next = S_ACC;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.take      = take;
    cmd.load      = state == S_LOAD;
    cmd.sqrt_step = state == S_SQRT;
    cmd.mul       = state == S_MUL;
    cmd.div_step  = state == S_DIV;
    cmd.out_load  = (state == S_OUT) && slot_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_ACC;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTH
  a_last_flush: assert property (@(posedge clk) disable iff (rst)
    (take && last_pair) |=> (state == S_FLUSH))
    else $error("last word did not start the result sequence");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || !out_stall))
    else $error("result register written while a result waits");
  a_rose_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_OUT))
    else $error("result appeared outside the hand-off state");
`endif

endmodule
`default_nettype wire

// ===== rtl/cosine_similarity.sv =====
// Top level of the cosine similarity block: controller and datapath.
`timescale 1ns / 1ps
`default_nettype none
// Cosine similarity of two Q1.15 vectors. One element pair is accepted per cycle
// while a vector streams in; the word with last_pair set closes the vector. After
// that word the input stalls while the product stage is flushed and the sums are
// captured, the digit-serial square roots of both norms are taken (one root bit
// per cycle), the roots are multiplied, the restoring divider runs (one quotient
// bit per cycle) and the result register is written. The stall lasts longer
// while the previous result still waits at the output. The result is Q1.15
// saturated; zero_norm reports a zero norm (similarity then 0) and too_long
// reports more than MAX_LEN pairs.
module cosine_similarity #(
  parameter int MAX_LEN = cossim_pkg::MAX_LEN_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic signed [cossim_pkg::ELEM_W-1:0] elem_a,
  input  wire logic signed [cossim_pkg::ELEM_W-1:0] elem_b,
  input  wire logic                                 last_pair,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic signed [cossim_pkg::ELEM_W-1:0]      similarity,
  output logic                                      zero_norm,
  output logic                                      too_long
);
  import cossim_pkg::*;

  cmd_t cmd;
  sts_t sts;

  cossim_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .last_pair (last_pair),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  cossim_dp #(
    .MAX_LEN (MAX_LEN)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .elem_a     (elem_a),
    .elem_b     (elem_b),
    .similarity (similarity),
    .zero_norm  (zero_norm),
    .too_long   (too_long)
  );

endmodule
`default_nettype wire
